// ===== sv/iso_pkg.sv =====
// Shared types and constants for the insertion sorter.
`timescale 1ns / 1ps
`default_nettype none

package iso_pkg;

    // Element width, fixed by the item format
    localparam int DATA_W = 32;

    // Default store depth
    localparam int MAX_ITEMS_DEF = 64;

    // Controller states
    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;    // insert the broadcast value
        logic shift;  // move every entry one cell toward the head
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== sv/insertion_sorter_core.sv =====
// Top level of the insertion sorter: cell chain, load/drain control, output register.
`timescale 1ns / 1ps
`default_nettype none

// Stable ascending sorter for sets of signed 32-bit items. While a set loads,
// one item is taken every cycle: each item is compared against all cells of
// the chain at once and slotted in behind every entry less than or equal to
// it. Items arriving while all MAX_ITEMS cells are full are dropped and the
// overflow flag is set on every result of that set. After the item flagged
// last, the input stalls while the chain shifts out toward the head, one
// result per cycle when the output is not stalled; the final result carries
// last_out. New input is taken again as soon as the last result enters the
// output register.
module insertion_sorter_core #(
    parameter int MAX_ITEMS = iso_pkg::MAX_ITEMS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic signed [iso_pkg::DATA_W-1:0]   i_value,
    input  wire logic                                i_last_in,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic signed [iso_pkg::DATA_W-1:0]        o_sorted_value,
    output logic                                     o_last_out,
    output logic                                     o_overflow
);

    logic                                r_state;
    logic                                r_dropped;
    logic                                r_out_valid;
    logic signed [iso_pkg::DATA_W-1:0]   r_out_value;
    logic                                r_out_last;
    logic                                r_out_ovf;

    iso_pkg::t_cell_ctrl                 w_ctrl;
    logic [MAX_ITEMS-1:0]                w_valid;
    logic [MAX_ITEMS-1:0]                w_take;
    logic signed [iso_pkg::DATA_W-1:0]   w_value [MAX_ITEMS];

    logic                                w_in_accept;
    logic                                w_full;
    logic                                w_out_free;
    logic                                w_pop;
    logic                                w_pop_last;

    // Handshake and chain status
    assign o_stall     = (r_state == iso_pkg::ST_DRAIN);
    assign w_in_accept = i_valid && !o_stall;
    assign w_full      = w_valid[MAX_ITEMS-1];
    assign w_out_free  = !r_out_valid || !i_stall;
    assign w_pop       = (r_state == iso_pkg::ST_DRAIN) && w_out_free && w_valid[0];
    assign w_pop_last  = w_pop && !w_valid[1];

    assign w_ctrl.ins   = w_in_accept && !w_full;
    assign w_ctrl.shift = w_pop;

    // Cell chain
    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
            logic                                w_lv;
            logic signed [iso_pkg::DATA_W-1:0]   w_lval;
            logic                                w_ltake;
            logic                                w_rv;
            logic signed [iso_pkg::DATA_W-1:0]   w_rval;

            if (gi == 0) begin : g_head
                assign w_lv    = 1'b1;
                assign w_lval  = i_value;
                assign w_ltake = 1'b0;
            end else begin : g_mid_l
                assign w_lv    = w_valid[gi-1];
                assign w_lval  = w_value[gi-1];
                assign w_ltake = w_take[gi-1];
            end

            if (gi == MAX_ITEMS-1) begin : g_tail
                assign w_rv   = 1'b0;
                assign w_rval = '0;
            end else begin : g_mid_r
                assign w_rv   = w_valid[gi+1];
                assign w_rval = w_value[gi+1];
            end

            iso_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (w_ctrl),
                .i_value       (i_value),
                .i_left_valid  (w_lv),
                .i_left_value  (w_lval),
                .i_left_take   (w_ltake),
                .i_right_valid (w_rv),
                .i_right_value (w_rval),
                .o_valid       (w_valid[gi]),
                .o_value       (w_value[gi]),
                .o_take        (w_take[gi])
            );
        end
    endgenerate

    // Load/drain control and dropped flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= iso_pkg::ST_LOAD;
            r_dropped <= 1'b0;
        end else begin
            case (r_state)
                iso_pkg::ST_LOAD: begin
                    if (w_in_accept) begin
                        if (w_full) begin
                            r_dropped <= 1'b1;
                        end
                        if (i_last_in) begin
                            r_state <= iso_pkg::ST_DRAIN;
                        end
                    end
                end
                iso_pkg::ST_DRAIN: begin
                    if (w_pop_last) begin
                        r_state   <= iso_pkg::ST_LOAD;
                        r_dropped <= 1'b0;
                    end
                end
                default: begin
                    r_state <= iso_pkg::ST_LOAD;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_out_value <= w_value[0];
            r_out_last  <= !w_valid[1];
            r_out_ovf   <= r_dropped;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sorted_value = r_out_value;
    assign o_last_out     = r_out_last;
    assign o_overflow     = r_out_ovf;

    // Occupied cells always form one run from the head
    logic w_contig;
    assign w_contig = &(~w_valid[MAX_ITEMS-1:1] | w_valid[MAX_ITEMS-2:0]);

    a_contig : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_contig)
        else $error("cell chain has a hole");

    a_drain_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == iso_pkg::ST_DRAIN) |-> w_valid[0])
        else $error("draining an empty chain");

    a_drop_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == iso_pkg::ST_LOAD && r_dropped) |-> w_full)
        else $error("dropped flag set with room left");

    a_last_drains : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && i_last_in) |=> (r_state == iso_pkg::ST_DRAIN))
        else $error("set end did not start the drain");

endmodule

`default_nettype wire

// ===== sv/iso_cell.sv =====
// One cell of the sorting chain: holds one element and its valid bit.
`timescale 1ns / 1ps
`default_nettype none

module iso_cell (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire iso_pkg::t_cell_ctrl                 i_ctrl,
    input  wire logic signed [iso_pkg::DATA_W-1:0]   i_value,
    input  wire logic                                i_left_valid,
    input  wire logic signed [iso_pkg::DATA_W-1:0]   i_left_value,
    input  wire logic                                i_left_take,
    input  wire logic                                i_right_valid,
    input  wire logic signed [iso_pkg::DATA_W-1:0]   i_right_value,
    output logic                                     o_valid,
    output logic signed [iso_pkg::DATA_W-1:0]        o_value,
    output logic                                     o_take
);

    logic                                r_valid;
    logic signed [iso_pkg::DATA_W-1:0]   r_value;
    logic                                n_valid;
    logic signed [iso_pkg::DATA_W-1:0]   n_value;

    // This cell is at or past the insertion point: empty, or strictly greater
    // than the new element (equal entries stay ahead, keeping arrival order).
    assign o_take = !r_valid || (r_value > i_value);

    // Next contents
    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_ctrl.shift) begin
            n_valid = i_right_valid;
            n_value = i_right_value;
        end else if (i_ctrl.ins) begin
            n_valid = r_valid | i_left_valid;
            if (o_take) begin
                n_value = i_left_take ? i_left_value : i_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_valid = r_valid;
    assign o_value = r_value;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the insertion sorter: sets in, sorted results compared.
`timescale 1ns / 1ps

module tb;

    localparam int SORT_DEPTH   = iso_pkg::MAX_ITEMS_DEF;
    localparam int LIMIT_CYCLES = 400000;
    localparam int IDLE_PCT     = 21;
    localparam int TAIL_CYCLES  = 2 * SORT_DEPTH + 8;
    localparam int MAX_SHOWN    = 10;

    // one sorted result as it should leave the block
    typedef struct packed {
        logic signed [iso_pkg::DATA_W-1:0] value;
        logic                              last;
        logic                              ovf;
    } t_sorted_rec;

    logic                              i_clk     = 1'b0;
    logic                              i_rst_n   = 1'b0;
    logic                              i_valid   = 1'b0;
    logic signed [iso_pkg::DATA_W-1:0] i_value   = '0;
    logic                              i_last_in = 1'b0;
    logic                              i_stall   = 1'b0;
    logic                              o_stall;
    logic                              o_valid;
    logic signed [iso_pkg::DATA_W-1:0] o_sorted_value;
    logic                              o_last_out;
    logic                              o_overflow;

    // shadow of the block: ascending values held for the open set
    logic signed [iso_pkg::DATA_W-1:0] held_vals[$];
    logic                              set_dropped = 1'b0;
    t_sorted_rec                       pending_sorted[$];

    bit calm = 1'b0;    // no idling on either side while set
    int err_count    = 0;
    int items_sent   = 0;
    int sets_sent    = 0;
    int results_seen = 0;
    int cycle_count  = 0;

    insertion_sorter_core #(
        .MAX_ITEMS(SORT_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_value       (i_value),
        .i_last_in     (i_last_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_sorted_value(o_sorted_value),
        .o_last_out    (o_last_out),
        .o_overflow    (o_overflow)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_sorted.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // stable insert; on the set's last item, queue the whole set in order
    task automatic predict_sorted(input logic signed [iso_pkg::DATA_W-1:0] v,
                                  input logic last);
        int pos;
        t_sorted_rec rec;
        if (held_vals.size() < SORT_DEPTH) begin
            pos = held_vals.size();
            while (pos > 0 && held_vals[pos-1] > v) pos--;
            held_vals.insert(pos, v);
        end else begin
            set_dropped = 1'b1;
        end
        if (last) begin
            foreach (held_vals[k]) begin
                rec.value = held_vals[k];
                rec.last  = (k == held_vals.size() - 1);
                rec.ovf   = set_dropped;
                pending_sorted = {pending_sorted, rec};
            end
            held_vals.delete();
            set_dropped = 1'b0;
            sets_sent++;
        end
    endtask

    // present one item, hold it until taken, then predict
    task automatic send_item(input logic signed [iso_pkg::DATA_W-1:0] v, input logic last);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_value   <= v;
        i_last_in <= last;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        predict_sorted(v, last);
    endtask

    // full range, tight cluster (forces ties), or near the limits
    function automatic logic signed [iso_pkg::DATA_W-1:0] rand_value();
        logic signed [iso_pkg::DATA_W-1:0] r;
        case ($urandom_range(0, 3))
            0, 1: r = $urandom;
            2:    r = $signed($urandom_range(0, 8)) - 4;
            default: begin
                r = $urandom_range(0, 3);
                if ($urandom_range(0, 1)) r = 32'sh7FFF_FFFF - r;
                else                     r = 32'sh8000_0000 + r;
            end
        endcase
        return r;
    endfunction

    task automatic send_set(input int n);
        for (int k = 0; k < n; k++) send_item(rand_value(), k == n - 1);
    endtask

    // result side: random stall, compare each accepted result
    always @(posedge i_clk) begin
        t_sorted_rec want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pending_sorted.size() == 0) begin
                err_count++;
                if (err_count <= MAX_SHOWN)
                    $display("unexpected result value=%0d last=%0b ovf=%0b",
                             o_sorted_value, o_last_out, o_overflow);
            end else begin
                want = pending_sorted.pop_front();
                if (o_sorted_value !== want.value || o_last_out !== want.last ||
                    o_overflow !== want.ovf) begin
                    err_count++;
                    if (err_count <= MAX_SHOWN)
                        $display("mismatch at result %0d: exp %0d/%0b/%0b got %0d/%0b/%0b",
                                 results_seen, want.value, want.last, want.ovf,
                                 o_sorted_value, o_last_out, o_overflow);
                end
            end
        end
        i_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // single-item sets at the value extremes, zero and minus one
    task automatic test_single_extremes();
        send_item(32'sh8000_0000, 1'b1);
        send_item(32'sh7FFF_FFFF, 1'b1);
        send_item(32'sh0, 1'b1);
        send_item(-32'sh1, 1'b1);
    endtask

    // extremes and alternating bit patterns in one set
    task automatic test_extreme_mix();
        send_item(32'sh7FFF_FFFF, 1'b0);
        send_item(32'sh8000_0000, 1'b0);
        send_item(-32'sh1, 1'b0);
        send_item(32'sh0, 1'b0);
        send_item(32'sh1, 1'b0);
        send_item(32'sh8000_0000, 1'b0);
        send_item(32'sh7FFF_FFFF, 1'b0);
        send_item(32'sh5555_5555, 1'b0);
        send_item($signed(32'hAAAA_AAAA), 1'b1);
    endtask

    // ties, then a strictly descending set (every insert goes to the head)
    task automatic test_ties_and_reverse();
        send_item(32'sd5, 1'b0);
        send_item(32'sd5, 1'b0);
        send_item(-32'sd5, 1'b0);
        send_item(32'sd5, 1'b0);
        send_item(-32'sd5, 1'b0);
        send_item(32'sd5, 1'b1);
        for (int k = 3; k >= 0; k--) send_item(k, k == 0);
    endtask

    // exactly full, then full with drops (last item itself dropped)
    task automatic test_capacity();
        send_set(SORT_DEPTH);
        send_set(SORT_DEPTH + 3);
        send_set(1);
    endtask

    // mostly short sets, now and then a long one
    task automatic test_random_sets(input int n_items);
        int done_items;
        int n;
        done_items = 0;
        while (done_items < n_items) begin
            if ($urandom_range(0, 15) == 0) n = $urandom_range(20, SORT_DEPTH);
            else                            n = $urandom_range(1, 10);
            send_set(n);
            done_items += n;
        end
    endtask

    // back-to-back traffic with no idling on either side
    task automatic test_back_to_back();
        calm = 1'b1;
        send_set(1);
        send_set(7);
        send_set(12);
        send_set(2);
        send_set(9);
        calm = 1'b0;
    endtask

    // drain, let the block settle, report
    task automatic finish_run();
        i_valid <= 1'b0;
        while (pending_sorted.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d sets / %0d items, %0d sorted results compared",
                 sets_sent, items_sent, results_seen);
        $display("included ties, value extremes, a full store and a store that dropped items");
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatching results", err_count);
            $display("DONE: errors detected");
        end
        $finish;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_single_extremes();
        test_extreme_mix();
        test_ties_and_reverse();
        test_capacity();
        test_random_sets(74);
        test_back_to_back();
        finish_run();
    end

endmodule

// ===== sim.f =====
sv/iso_pkg.sv
sv/iso_cell.sv
sv/insertion_sorter_core.sv
bench/tb.sv
